[src/bfsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bfsr_pkg;

  // Storage geometry of the queue.
  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;

  // Field widths of the two channels and of the capacity register.
  localparam int KIND_W  = 3;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 4;
  localparam int ST_W    = 3;
  localparam int FCNT_W  = 5;
  localparam int CAP_W   = 5;

  // Derived widths.
  localparam int AW      = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int STORE_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ   = 3'd0,
    KIND_DEQ   = 3'd1,
    KIND_FIND  = 3'd2,
    KIND_PLUCK = 3'd3,
    KIND_INDEX = 3'd4
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  index;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data;
    logic [FCNT_W-1:0] count;
    logic [FCNT_W-1:0] high_water;
  } out_item_t;

endpackage

`default_nettype wire

[src/bfsr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/bfsr_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfsr_engine
  import bfsr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire logic             in_valid,
  input  wire in_item_t         in_item,
  output logic                  busy,
  output logic                  res_valid,
  output out_item_t             res,
  input  wire logic             out_free
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    peak_r, peak_nxt;
  logic [CAP_W-1:0]    cap_r, cap_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [STORE_W-1:0]  value_r, value_nxt;
  logic [CNT_W-1:0]    issue_r, issue_nxt;
  logic                chk_v_r, chk_v_nxt;
  logic [AW-1:0]       chk_pos_r, chk_pos_nxt;
  status_t             status_r, status_nxt;
  logic [STORE_W-1:0]  data_r, data_nxt;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [STORE_W-1:0]  ram_wdata, ram_rdata;

  logic                accept, match, more, last, idx_ok, full, empty;
  logic [CMP_W-1:0]    limit;
  logic [CNT_W-1:0]    count_inc;

  bfsr_ram #(
    .WIDTH (STORE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective capacity never exceeds the storage depth.
  assign limit = (CMP_W'(cap_r) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_r);
  assign full      = CMP_W'(count_r) >= limit;
  assign empty     = count_r == '0;
  assign idx_ok    = CMP_W'(in_item.index) < CMP_W'(count_r);
  assign count_inc = count_r + CNT_W'(1);
  assign accept    = in_valid && (state_r == S_IDLE);

  // The walk issues one read per cycle; the compare sees the registered word from the previous read.
  assign more  = issue_r < count_r;
  assign match = chk_v_r && (ram_rdata == value_r);
  assign last  = chk_v_r && ((CNT_W'(chk_pos_r) + CNT_W'(1)) == count_r);

  assign busy      = state_r != S_IDLE;
  assign res_valid = state_r == S_DONE;

  always_comb begin
    res.status     = status_r;
    res.data       = DATA_W'(data_r);
    res.count      = FCNT_W'(count_r);
    res.high_water = FCNT_W'(peak_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item.kind)
            KIND_DEQ:               state_nxt = empty ? S_DONE : S_READ;
            KIND_FIND, KIND_PLUCK:  state_nxt = empty ? S_DONE : S_SEARCH;
            KIND_INDEX:             state_nxt = idx_ok ? S_READ : S_DONE;
            default:                state_nxt = S_DONE;
          endcase
        end
      end
      S_SEARCH: begin
        if (match) begin
          state_nxt = (kind_r == KIND_PLUCK) ? S_SHIFT : S_DONE;
        end else if (last) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: begin
        state_nxt = (kind_r == KIND_DEQ) ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        if (!more && !chk_v_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    peak_nxt    = peak_r;
    cap_nxt     = cfg_valid ? cfg_data : cap_r;
    kind_nxt    = kind_r;
    value_nxt   = value_r;
    issue_nxt   = issue_r;
    chk_v_nxt   = chk_v_r;
    chk_pos_nxt = chk_pos_r;
    status_nxt  = status_r;
    data_nxt    = data_r;
    ram_we      = 1'b0;
    ram_waddr   = count_r[AW-1:0];
    ram_wdata   = in_item.value[STORE_W-1:0];
    ram_re      = 1'b0;
    ram_raddr   = issue_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt   = in_item.kind;
          value_nxt  = in_item.value[STORE_W-1:0];
          status_nxt = ST_OK;
          data_nxt   = '0;
          issue_nxt  = '0;
          chk_v_nxt  = 1'b0;
          unique case (in_item.kind)
            KIND_ENQ: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                count_nxt = count_inc;
                if (count_inc > peak_r) begin
                  peak_nxt = count_inc;
                end
              end
            end
            KIND_DEQ: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
              end
            end
            KIND_FIND, KIND_PLUCK: begin
              if (empty) begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            KIND_INDEX: begin
              if (!idx_ok) begin
                status_nxt = ST_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_item.index);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEARCH: begin
        ram_re      = more;
        issue_nxt   = more ? issue_r + CNT_W'(1) : issue_r;
        chk_v_nxt   = more;
        chk_pos_nxt = issue_r[AW-1:0];
        if (match) begin
          data_nxt  = ram_rdata;
          chk_v_nxt = 1'b0;
          // A pluck closes the gap starting with the entry behind the match.
          issue_nxt = CNT_W'(chk_pos_r) + CNT_W'(1);
        end else if (last) begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      S_READ: begin
        data_nxt = ram_rdata;
        if (kind_r == KIND_DEQ) begin
          issue_nxt = CNT_W'(1);
          chk_v_nxt = 1'b0;
        end
      end
      S_SHIFT: begin
        ram_re      = more;
        issue_nxt   = more ? issue_r + CNT_W'(1) : issue_r;
        chk_v_nxt   = more;
        chk_pos_nxt = issue_r[AW-1:0];
        if (chk_v_r) begin
          ram_we    = 1'b1;
          ram_waddr = chk_pos_r - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (!more && !chk_v_r) begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      peak_r  <= '0;
      cap_r   <= CAP_RESET;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      peak_r  <= peak_nxt;
      cap_r   <= cap_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    value_r   <= value_nxt;
    issue_r   <= issue_nxt;
    chk_pos_r <= chk_pos_nxt;
    status_r  <= status_nxt;
    data_r    <= data_nxt;
  end

endmodule

`default_nettype wire

[src/bfsr_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfsr_out
  import bfsr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      res_valid,
  input  wire out_item_t res,
  output logic           free,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic      valid_r, valid_nxt;
  out_item_t item_r, item_nxt;
  logic      load;

  // The register can take a new item when empty or when its item leaves now.
  assign free = !valid_r || !out_stall;
  assign load = res_valid && free;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = 1'b1;
      item_nxt  = res;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

`default_nettype wire

[src/bounded_fifo_with_search_remove_unit.sv]
// Ordered queue of words with enqueue, dequeue, find, pluck and read at index.
// Input channel (in_valid, in_stall, in_item): one operation per item. An item
// is taken at a clock edge with in_valid high and in_stall low. The unit works
// on one item at a time and holds in_stall high until that item is finished.
// Result channel (out_valid, out_stall, out_item): exactly one result per item,
// with status, data, count after the operation and the high-water mark.
// Configuration channel (cfg_valid, cfg_ready, cfg_data): writes the capacity;
// cfg_ready is always high, and writes belong to times when the unit is idle.
// Enqueue, unknown kinds and failures found without a walk (full, empty, index
// out of range, find or pluck on an empty queue) go straight to the result;
// read at index reads the one entry; find and pluck walk the entries from the
// head until a match or the last entry. After a dequeue of the head or a pluck
// of its match, removal walks the entries behind the removed one through the
// single read port, one entry per cycle. The next item is taken at the
// earliest in the cycle after out_valid rises.
// A finished result waits in the output register while out_stall is high; the
// unit then accepts the next item and holds its own result until the register
// frees up. Reset empties the queue, clears the high-water mark and sets the
// capacity to 16; the entry memory itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module bounded_fifo_with_search_remove_unit
  import bfsr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  logic      busy;
  logic      res_valid;
  out_item_t res;
  logic      out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;

  bfsr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .busy      (busy),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free)
  );

  bfsr_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

[src/bfsr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bfsr_checker
  import bfsr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or vanished");

  // One item at a time: the unit is busy right after it takes an item.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while the previous one is in flight");

  // The high-water mark never trails the current count.
  a_high_water: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.high_water >= out_item.count)
    else $error("high-water mark below count");

  // Failed operations return no data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_OK) |-> out_item.data == '0)
    else $error("failed operation returned data");

  // Status is one of the defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_OK) || (out_item.status == ST_FULL) ||
                  (out_item.status == ST_EMPTY) || (out_item.status == ST_NOT_FOUND) ||
                  (out_item.status == ST_RANGE))
    else $error("undefined status code");

endmodule

bind bounded_fifo_with_search_remove_unit bfsr_checker u_bfsr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
